// ===== src/bpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator: map word width,
// item kind codes, configuration register indexes and the word-evaluation
// result that travels from the word evaluator to the top-level sequencer.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Pages held in one word of the used map
  localparam int WORD_W     = 32;
  localparam int WORD_IDX_W = 5;   // bits to select a page inside a word
  localparam int WORD_CNT_W = 6;   // bits to count 0..WORD_W pages

  // Input item kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Configuration register indexes
  localparam int             CFG_IDX_W        = 2;
  localparam int             CFG_DATA_W       = 32;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [31:0] RESET_REGION_START = 32'h0010_0000;
  localparam logic [12:0] RESET_PAGES_IN_USE = 13'd4096;
  localparam logic [4:0]  RESET_PAGE_SHIFT   = 5'd12;

  // Result of evaluating one map word during the first-fit scan
  typedef struct packed {
    logic                  fit;         // a run fits entirely inside the word
    logic [WORD_IDX_W-1:0] pos;         // lowest start of such a run
    logic [WORD_CNT_W-1:0] trail_free;  // free pages counted up from bit 0
    logic [WORD_CNT_W-1:0] lead_free;   // free pages counted down from the top bit
  } word_eval_t;

endpackage
`default_nettype wire

// ===== src/bpa_word_eval.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_word_eval
// Evaluates one 32-page word of the used map for the first-fit scan: finds
// the lowest in-word start of a free run of the requested length and counts
// the free pages at both ends of the word for runs that cross word borders.
// ----------------------------------------------------------------------------
module bpa_word_eval (
  input  wire logic [bpa_pkg::WORD_W-1:0] used,      // 1 = page used or out of range
  input  wire logic [bpa_pkg::WORD_W-1:0] run_mask,  // ones over the run length
  input  wire logic [bpa_pkg::WORD_W-1:0] fit_lim,   // bit p: run starting at p ends in word
  output bpa_pkg::word_eval_t             eval
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] fit_vec;

  // One independent window test per start position
  always_comb begin
    for (int p = 0; p < WORD_W; p++) begin
      fit_vec[p] = fit_lim[p] && ((used & (run_mask << p)) == '0);
    end
  end

  // Priority encoders: lowest fitting start, free pages at each end
  always_comb begin
    eval.fit        = |fit_vec;
    eval.pos        = '0;
    eval.trail_free = WORD_CNT_W'(WORD_W);
    eval.lead_free  = WORD_CNT_W'(WORD_W);
    for (int p = WORD_W - 1; p >= 0; p--) begin
      if (fit_vec[p]) begin
        eval.pos = WORD_IDX_W'(p);
      end
      if (used[p]) begin
        eval.trail_free = WORD_CNT_W'(p);
      end
    end
    for (int b = 0; b < WORD_W; b++) begin
      if (used[b]) begin
        eval.lead_free = WORD_CNT_W'(WORD_W - 1 - b);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/bitmap_page_allocator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// First-fit contiguous page allocator over a one-bit-per-page used map held
// in a synchronous word memory.
// ----------------------------------------------------------------------------
// The used map lives in a single memory of ceil(MAX_PAGES/32) words of 32
// pages, read through a registered read port. After reset a clearing pass
// writes every word to zero, one word per cycle; no item is accepted during
// it, configuration writes are taken at any time. One item is worked at a
// time. An allocate scans the map one word per cycle from page 0 up to the
// first fitting run, scanning at most ceil(pages_in_use/32) words. Each word
// that a run touches, on an allocate or a free, is marked by a read in
// S_MARK_RD and a write in S_MARK_WR; a zero-length or oversized allocate
// fails without a scan. The result sits in an output register, so the next
// transaction is accepted while it waits.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top #(
  parameter int MAX_PAGES = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           kind,
  input  wire logic [12:0]                    req_pages,
  input  wire logic [31:0]                    target_addr,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [31:0]                         result_addr,
  output logic                                failed
);
  import bpa_pkg::*;

  // Geometry
  localparam int NWORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int NW     = $clog2(MAX_PAGES + 1);
  localparam int CW     = (NW > 13) ? NW : 13;
  localparam logic [CW-1:0] MAXP      = CW'(MAX_PAGES);
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

  // Sequencer states
  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_ALLOC_CHK = 4'd2;
  localparam logic [3:0] S_SCAN      = 4'd3;
  localparam logic [3:0] S_FREE_CALC = 4'd4;
  localparam logic [3:0] S_MARK_RD   = 4'd5;
  localparam logic [3:0] S_MARK_WR   = 4'd6;
  localparam logic [3:0] S_ADDR      = 4'd7;
  localparam logic [3:0] S_OUT       = 4'd8;

  // Configuration registers
  logic [31:0] region_start;
  logic [12:0] pages_in_use;
  logic [4:0]  page_shift;

  // Control state
  logic [3:0]    state, state_next;
  logic [AW-1:0] clr_w;
  logic [AW-1:0] eval_w, eval_w_next;
  logic [AW-1:0] last_w, last_w_next;
  logic [AW-1:0] mark_w, mark_w_next;
  logic [CW-1:0] run_len, run_len_next;

  // Payload registers
  logic          kind_r;
  logic [12:0]   count_r;
  logic [31:0]   addr_r;
  logic [CW-1:0] run_start, run_start_next;
  logic [CW-1:0] rng_lo, rng_lo_next;
  logic [CW-1:0] rng_hi, rng_hi_next;
  logic          set_bits, set_bits_next;
  logic [31:0]   res_addr, res_addr_next;
  logic          res_fail, res_fail_next;

  // Used-map memory
  logic [WORD_W-1:0] mem [NWORDS];
  logic [WORD_W-1:0] rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= RESET_REGION_START;
      pages_in_use <= RESET_PAGES_IN_USE;
      page_shift   <= RESET_PAGE_SHIFT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REGION_START: region_start <= cfg_data;
        REG_PAGES_IN_USE: pages_in_use <= cfg_data[12:0];
        REG_PAGE_SHIFT:   page_shift   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Effective page count and derived limits
  logic [CW-1:0] n_c;
  logic [CW-1:0] nm1;
  logic [CW-1:0] count_c;
  assign n_c     = (CW'(pages_in_use) > MAXP) ? MAXP : CW'(pages_in_use);
  assign nm1     = n_c - CW'(1);
  assign count_c = CW'(count_r);

  // Run mask and in-word fit limits follow from the requested length
  logic [WORD_W-1:0] run_mask;
  logic [WORD_W-1:0] fit_lim;
  always_comb begin
    if (count_r[12:WORD_IDX_W] != '0) begin
      run_mask = '1;
    end else begin
      run_mask = ~({WORD_W{1'b1}} << count_r[WORD_IDX_W-1:0]);
    end
    for (int p = 0; p < WORD_W; p++) begin
      fit_lim[p] = count_r <= 13'(WORD_W - p);
    end
  end

  // Word under evaluation, pages past the managed range forced used
  logic [WORD_W-1:0] valid_mask;
  logic [WORD_W-1:0] used_word;
  word_eval_t        ev;
  assign valid_mask = {WORD_W{1'b1}} >> (~nm1[WORD_IDX_W-1:0]);
  assign used_word  = rdata | ((eval_w == last_w) ? ~valid_mask : '0);

  bpa_word_eval u_eval (
    .used     (used_word),
    .run_mask (run_mask),
    .fit_lim  (fit_lim),
    .eval     (ev)
  );

  // Scan arithmetic
  logic [CW-1:0] wbase;
  logic [CW:0]   run_sum;
  logic          cross_fit;
  logic [CW-1:0] found_start;
  assign wbase       = CW'({eval_w, {WORD_IDX_W{1'b0}}});
  assign run_sum     = (CW+1)'(run_len) + (CW+1)'(ev.trail_free);
  assign cross_fit   = (run_len != '0) && (run_sum >= (CW+1)'(count_r));
  assign found_start = cross_fit ? run_start : (wbase + CW'(ev.pos));

  // Free-range arithmetic
  logic [31:0] diff;
  logic [31:0] base;
  logic [32:0] end_x;
  logic        over;
  assign diff  = addr_r - region_start;
  assign base  = diff >> page_shift;
  assign end_x = {1'b0, base} + 33'(count_r);
  assign over  = end_x > 33'(n_c);

  // Mark mask for the current word of the range
  logic [AW-1:0]     lo_word;
  logic [AW-1:0]     hi_word;
  logic [WORD_W-1:0] mark_mask;
  assign lo_word = rng_lo[AW+WORD_IDX_W-1:WORD_IDX_W];
  assign hi_word = rng_hi[AW+WORD_IDX_W-1:WORD_IDX_W];
  always_comb begin
    mark_mask = '1;
    if (mark_w == lo_word) begin
      mark_mask = mark_mask & ({WORD_W{1'b1}} << rng_lo[WORD_IDX_W-1:0]);
    end
    if (mark_w == hi_word) begin
      mark_mask = mark_mask & ({WORD_W{1'b1}} >> (~rng_hi[WORD_IDX_W-1:0]));
    end
  end

  // Handshakes
  logic in_acc;
  logic out_load;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // Sequencer
  always_comb begin
    state_next     = state;
    eval_w_next    = eval_w;
    last_w_next    = last_w;
    mark_w_next    = mark_w;
    run_len_next   = run_len;
    run_start_next = run_start;
    rng_lo_next    = rng_lo;
    rng_hi_next    = rng_hi;
    set_bits_next  = set_bits;
    res_addr_next  = res_addr;
    res_fail_next  = res_fail;
    mem_we         = 1'b0;
    mem_waddr      = mark_w;
    mem_wdata      = '0;
    mem_raddr      = mark_w;

    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_w;
        if (clr_w == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          state_next = (kind == KIND_ALLOC) ? S_ALLOC_CHK : S_FREE_CALC;
        end
      end

      // Reject empty or oversized requests, else start reading word 0
      S_ALLOC_CHK: begin
        res_addr_next = '0;
        if (count_r == '0 || count_c > n_c) begin
          res_fail_next = 1'b1;
          state_next    = S_OUT;
        end else begin
          eval_w_next   = '0;
          last_w_next   = nm1[AW+WORD_IDX_W-1:WORD_IDX_W];
          run_len_next  = '0;
          mem_raddr     = '0;
          set_bits_next = 1'b1;
          state_next    = S_SCAN;
        end
      end

      // One word per cycle; the next word is read while this one is checked
      S_SCAN: begin
        mem_raddr = (eval_w == last_w) ? eval_w : AW'(eval_w + AW'(1));
        if (cross_fit || ev.fit) begin
          rng_lo_next = found_start;
          rng_hi_next = found_start + count_c - CW'(1);
          mark_w_next = found_start[AW+WORD_IDX_W-1:WORD_IDX_W];
          state_next  = S_MARK_RD;
        end else if (eval_w == last_w) begin
          res_fail_next = 1'b1;
          state_next    = S_OUT;
        end else begin
          eval_w_next = AW'(eval_w + AW'(1));
          if (ev.trail_free == WORD_CNT_W'(WORD_W)) begin
            run_len_next = run_len + CW'(WORD_W);
            if (run_len == '0) begin
              run_start_next = wbase;
            end
          end else begin
            run_len_next   = CW'(ev.lead_free);
            run_start_next = wbase + CW'(WORD_W) - CW'(ev.lead_free);
          end
        end
      end

      // Work out the page range of a free and its out-of-region flag
      S_FREE_CALC: begin
        res_addr_next = '0;
        res_fail_next = 1'b0;
        set_bits_next = 1'b0;
        state_next    = S_OUT;
        if (count_r != '0) begin
          if (addr_r < region_start) begin
            res_fail_next = 1'b1;
          end else begin
            res_fail_next = over;
            if (base < 32'(n_c)) begin
              rng_lo_next = base[CW-1:0];
              rng_hi_next = (over ? n_c : end_x[CW-1:0]) - CW'(1);
              mark_w_next = base[AW+WORD_IDX_W-1:WORD_IDX_W];
              state_next  = S_MARK_RD;
            end
          end
        end
      end

      S_MARK_RD: begin
        mem_raddr  = mark_w;
        state_next = S_MARK_WR;
      end

      // Read-modify-write of one word of the range
      S_MARK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mark_w;
        mem_wdata = set_bits ? (rdata | mark_mask) : (rdata & ~mark_mask);
        if (mark_w == hi_word) begin
          state_next = set_bits ? S_ADDR : S_OUT;
        end else begin
          mark_w_next = AW'(mark_w + AW'(1));
          state_next  = S_MARK_RD;
        end
      end

      S_ADDR: begin
        res_addr_next = region_start + (32'(rng_lo) << page_shift);
        res_fail_next = 1'b0;
        state_next    = S_OUT;
      end

      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_w   <= '0;
      eval_w  <= '0;
      last_w  <= '0;
      mark_w  <= '0;
      run_len <= '0;
    end else begin
      state   <= state_next;
      eval_w  <= eval_w_next;
      last_w  <= last_w_next;
      mark_w  <= mark_w_next;
      run_len <= run_len_next;
      if (state == S_CLEAR) begin
        clr_w <= AW'(clr_w + AW'(1));
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= kind;
      count_r <= req_pages;
      addr_r  <= target_addr;
    end
    run_start <= run_start_next;
    rng_lo    <= rng_lo_next;
    rng_hi    <= rng_hi_next;
    set_bits  <= set_bits_next;
    res_addr  <= res_addr_next;
    res_fail  <= res_fail_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      // a free never reports an address
      result_addr <= (kind_r == KIND_FREE) ? 32'd0 : res_addr;
      failed      <= res_fail;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap page allocator. A scoreboard keeps its
// own copy of the used map and the configuration, predicts the grant or the
// release outcome of every accepted transaction and compares each returned
// result against the oldest prediction. A short directed sequence covers the
// corner cases; randomized phases under several configurations follow, with
// bursty input traffic, a randomly stalling result side and long hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
  import bpa_pkg::*;

  localparam int PAGES = 4096;

  // Predicted outcome of one transaction
  typedef struct packed {
    logic [31:0] addr;
    logic        fail;
  } alloc_outcome_t;

  // Scoreboard: shadow used map, shadow registers, queue of expected outcomes
  class page_map_scoreboard;
    bit             used_map [PAGES];
    logic [31:0]    region_base;
    logic [12:0]    page_total;
    logic [4:0]     shift;
    alloc_outcome_t outcome_q [$];
    int             error_count;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      region_base = RESET_REGION_START;
      page_total  = RESET_PAGES_IN_USE;
      shift       = RESET_PAGE_SHIFT;
      error_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_REGION_START: region_base = data;
        REG_PAGES_IN_USE: page_total  = data[12:0];
        REG_PAGE_SHIFT:   shift       = data[4:0];
        default: ;
      endcase
    endfunction

    // sizes above the built capacity act as the capacity
    function int unsigned active_pages();
      return (page_total > PAGES) ? PAGES : int'(page_total);
    endfunction

    function logic [31:0] page_addr(int unsigned page);
      logic [63:0] full;
      full = 64'(region_base) + (64'(page) << shift);
      return full[31:0];
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // first-fit search; marks the run used on success
    function void claim_first_fit(int unsigned count, output logic [31:0] addr,
                                  output logic fail);
      int unsigned n;
      int unsigned run;
      int unsigned first;
      n    = active_pages();
      run  = 0;
      addr = '0;
      fail = 1'b1;
      if (count == 0 || count > n) return;
      for (int unsigned i = 0; i < n; i++) begin
        if (used_map[i]) begin
          run = 0;
          continue;
        end
        run++;
        if (run == count) begin
          first = i + 1 - count;
          for (int unsigned k = first; k <= i; k++) used_map[k] = 1'b1;
          addr = page_addr(first);
          fail = 1'b0;
          return;
        end
      end
    endfunction

    // clear a run of pages; anything outside the region flags the transaction
    function void release_run(logic [31:0] adr, int unsigned count, output logic fail);
      int unsigned n;
      logic [31:0] offset;
      logic [63:0] base_page;
      logic [63:0] idx;
      n    = active_pages();
      fail = 1'b0;
      if (count == 0) return;
      if (adr < region_base) begin
        fail = 1'b1;
        return;
      end
      offset    = adr - region_base;
      base_page = 64'(offset) >> shift;
      for (int unsigned j = 0; j < count; j++) begin
        idx = base_page + 64'(j);
        if (idx < 64'(n)) used_map[idx] = 1'b0;
        else fail = 1'b1;
      end
    endfunction

    function void note_request(logic k, logic [12:0] count, logic [31:0] adr);
      alloc_outcome_t o;
      if (k == KIND_ALLOC) begin
        claim_first_fit(count, o.addr, o.fail);
      end else begin
        o.addr = '0;
        release_run(adr, count, o.fail);
      end
      outcome_q.push_back(o);
    endfunction

    function void check_outcome(logic [31:0] addr, logic fail);
      alloc_outcome_t o;
      if (outcome_q.size() == 0) begin
        $error("unexpected result: result_addr %h failed %b", addr, fail);
        error_count++;
        return;
      end
      o = outcome_q.pop_front();
      if (addr !== o.addr) begin
        $error("result_addr mismatch: expected %h, actual %h", o.addr, addr);
        error_count++;
      end
      if (fail !== o.fail) begin
        $error("failed mismatch: expected %b, actual %b", o.fail, fail);
        error_count++;
      end
    endfunction

    // random used page inside the region, or -1 when none is used
    function int pick_used_page();
      int unsigned n;
      int unsigned start;
      int unsigned p;
      n = active_pages();
      if (n == 0) return -1;
      start = $urandom_range(0, n - 1);
      for (int unsigned i = 0; i < n; i++) begin
        p = (start + i) % n;
        if (used_map[p]) return int'(p);
      end
      return -1;
    endfunction
  endclass

  page_map_scoreboard sb = new();

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_REGION_START;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  kind        = KIND_ALLOC;
  logic [12:0]           req_pages   = '0;
  logic [31:0]           target_addr = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [31:0]           result_addr;
  logic                  failed;

  always #2 clk = ~clk;

  bitmap_page_allocator_top #(.MAX_PAGES(PAGES)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .req_pages   (req_pages),
    .target_addr (target_addr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_addr (result_addr),
    .failed      (failed)
  );

  // Write all three registers, one per cycle
  task automatic apply_setup(input logic [31:0] region, input logic [31:0] pages,
                             input logic [31:0] shift_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REGION_START;
    cfg_data  <= region;
    @(posedge clk);
    sb.set_reg(REG_REGION_START, region);
    cfg_index <= REG_PAGES_IN_USE;
    cfg_data  <= pages;
    @(posedge clk);
    sb.set_reg(REG_PAGES_IN_USE, pages);
    cfg_index <= REG_PAGE_SHIFT;
    cfg_data  <= shift_val;
    @(posedge clk);
    sb.set_reg(REG_PAGE_SHIFT, shift_val);
    cfg_we    <= 1'b0;
  endtask

  // Present one transaction and hold it until accepted
  task automatic offer(input logic k, input logic [12:0] cnt, input logic [31:0] adr);
    in_valid    <= 1'b1;
    kind        <= k;
    req_pages   <= cnt;
    target_addr <= adr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(k, cnt, adr);
  endtask

  // Stop offering, wait for every outstanding result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Bursty random traffic: mostly allocations and frees of live pages
  task automatic run_random(input int items);
    int          left;
    int          burst;
    int          pick;
    int          page;
    logic        k;
    logic [12:0] cnt;
    logic [31:0] adr;
    logic [63:0] mask;
    left = items;
    while (left > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      while (burst > 0 && left > 0) begin
        pick = $urandom_range(0, 99);
        adr  = $urandom;
        if (pick < 50) begin
          k    = KIND_ALLOC;
          pick = $urandom_range(0, 99);
          if (pick < 70)      cnt = 13'($urandom_range(1, 8));
          else if (pick < 90) cnt = 13'($urandom_range(9, 64));
          else if (pick < 97) cnt = 13'($urandom_range(65, 512));
          else if (pick < 98) cnt = '0;
          else                cnt = 13'($urandom_range(0, 8191));
        end else if (pick < 85) begin
          // free inside a live allocation, at a random offset within the page
          k    = KIND_FREE;
          page = sb.pick_used_page();
          mask = (64'd1 << sb.shift) - 64'd1;
          if (page >= 0) adr = sb.page_addr(page) + 32'(64'($urandom) & mask);
          cnt  = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(1, 64))
                                             : 13'($urandom_range(1, 8));
        end else begin
          // noise: arbitrary address and length
          k   = KIND_FREE;
          cnt = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                            : 13'($urandom_range(0, 16));
        end
        offer(k, cnt, adr);
        burst--;
        left--;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  endtask

  // Result side: random stall segments plus long hold-offs to back up the block
  initial begin : result_sink
    int seen;
    int hold_left;
    int seg_left;
    int seg_mode;
    bit next_stall;
    seen      = 0;
    hold_left = 0;
    seg_left  = 0;
    seg_mode  = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_outcome(result_addr, failed);
        seen++;
        if (seen == 60 || seen == 1000) hold_left = 400;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 80);
        seg_mode = $urandom_range(0, 3);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else begin
        case (seg_mode)
          0:       next_stall = 1'b0;
          1:       next_stall = 1'($urandom_range(0, 1));
          2:       next_stall = ($urandom_range(0, 3) != 0);
          default: next_stall = ($urandom_range(0, 5) == 0);
        endcase
      end
      out_stall <= next_stall;
    end
  end

  // Main sequence
  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    apply_setup(RESET_REGION_START, 32'(RESET_PAGES_IN_USE), 32'(RESET_PAGE_SHIFT));

    // directed corners at the default layout
    offer(KIND_ALLOC, 13'd0, 32'h0);                      // zero-length allocate
    offer(KIND_ALLOC, 13'd1, 32'hFFFF_FFFF);              // lands on page 0
    offer(KIND_ALLOC, 13'd4097, 32'h0);                   // larger than the region
    offer(KIND_ALLOC, 13'h1FFF, 32'h0);
    offer(KIND_ALLOC, 13'd3, 32'h0);
    offer(KIND_FREE, 13'd1, sb.page_addr(0));
    offer(KIND_ALLOC, 13'd1, 32'h0);                      // first fit reuses page 0
    offer(KIND_FREE, 13'd0, sb.page_addr(2) + 32'hABC);   // zero-length free
    offer(KIND_FREE, 13'd1, 32'h0);                       // below the region
    offer(KIND_FREE, 13'd1, 32'hFFFF_FFFF);               // beyond the region
    offer(KIND_FREE, 13'd2, sb.page_addr(4095));          // straddles the top
    offer(KIND_FREE, 13'd4, sb.page_addr(10));            // pages already free
    offer(KIND_ALLOC, 13'd4096, 32'h0);                   // no fitting run
    offer(KIND_FREE, 13'd4096, sb.page_addr(0));
    offer(KIND_ALLOC, 13'd4096, 32'h0);                   // whole region
    offer(KIND_ALLOC, 13'd1, 32'h0);                      // map full
    offer(KIND_FREE, 13'd4096, sb.page_addr(0));
    offer(KIND_ALLOC, 13'd8, 32'h0);
    drain();

    // shrink the region: upper used bits survive and are not released
    apply_setup(RESET_REGION_START, 32'd4, 32'd12);
    offer(KIND_FREE, 13'd8, sb.page_addr(0));
    offer(KIND_ALLOC, 13'd4, 32'h0);
    drain();
    apply_setup(RESET_REGION_START, 32'd4096, 32'd12);
    offer(KIND_ALLOC, 13'd4, 32'h0);
    offer(KIND_ALLOC, 13'd1, 32'h0);
    drain();

    // base address zero: a grant at address 0 is still a success
    apply_setup(32'h0, 32'd4096, 32'd0);
    offer(KIND_FREE, 13'h1FFF, 32'h0);
    offer(KIND_ALLOC, 13'd1, 32'h0);
    offer(KIND_FREE, 13'd4096, 32'h0);
    drain();

    // random phases across layouts
    apply_setup(RESET_REGION_START, 32'(RESET_PAGES_IN_USE), 32'(RESET_PAGE_SHIFT));
    run_random(400);
    drain();
    apply_setup(32'h0, 32'd64, 32'd0);
    run_random(250);
    drain();
    apply_setup(32'hFFFF_F000, 32'h1FFF, 32'd31);
    run_random(300);
    drain();
    apply_setup($urandom, 32'd1, 32'($urandom_range(0, 31)));
    run_random(100);
    drain();
    apply_setup($urandom, 32'd0, 32'($urandom_range(0, 31)));
    run_random(100);
    drain();
    repeat (3) begin
      apply_setup($urandom,
                  {19'($urandom_range(0, 32'h7FFFF)), 13'($urandom_range(1, 4096))},
                  {27'($urandom_range(0, 32'h7FF_FFFF)), 5'($urandom_range(0, 20))});
      run_random(216);
      drain();
    end

    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
